>>> src/dirv_pkg.sv
// Shared types and constants for the decimal integer range validator.
`timescale 1ns / 1ps

package dirv_pkg;

  localparam int RANGE_SLOTS_DEF = 3;
  localparam int VALUE_W         = 64;
  localparam int CHAR_W          = 8;
  localparam int COUNT_W         = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int OUT_DATA_W      = 72;

  localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE0_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE0_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE1_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE1_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE2_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE2_HIGH = 3'd6;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BADCHAR   = 3'd2,
    ST_TOOLARGE  = 3'd3,
    ST_OUT_RANGE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BADCHAR  = 2'd1,
    ERR_TOOLARGE = 2'd2
  } err_t;

  // Parsed value on its way to the range check
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } dirv_fin_t;

endpackage

>>> src/decimal_integer_range_validator.sv
// Top level: stream ports, configuration registers, parser and range check.
`timescale 1ns / 1ps
// The result of a value leaves through the parse-state/result register, then the range-check
//   result register, once its terminator request is taken. Throughput: one request per cycle
//   while in_tready is not held low; the 64-bit shift-add accumulator updates per character.
// Reset (rst_n low, synchronous): parse state cleared, both stages empty,
//   range_count 0, every range reset to the full signed 64-bit span.

module decimal_integer_range_validator
  import dirv_pkg::*;
#(
  parameter int RANGE_SLOTS = RANGE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CHAR_W-1:0]     in_tdata,   // [7:0] char_code
  input  logic                  in_tlast,   // end_of_value
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] valid_res, [64:1] int_value,
                                            // [67:65] status, [71:68] zero
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [COUNT_W-1:0]        range_count_r;
  logic signed [VALUE_W-1:0] range_low_r  [RANGE_SLOTS];
  logic signed [VALUE_W-1:0] range_high_r [RANGE_SLOTS];

  logic          fin_valid;
  logic          fin_ready;
  dirv_fin_t     fin;
  logic          valid_res;
  logic [VALUE_W-1:0] int_value;
  status_t       status;

  // Range count register; indexes past the list fall through untouched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_count_r <= '0;
    end else if (cfg_we && cfg_index == CFG_RANGE_COUNT) begin
      range_count_r <= cfg_wdata[COUNT_W-1:0];
    end
  end

  // Range bound registers: slot s low at 1+2s, high at 2+2s
  for (genvar s = 0; s < RANGE_SLOTS; s++) begin : g_slot
    localparam logic [CFG_IDX_W-1:0] LowIdx  = CFG_IDX_W'(int'(CFG_RANGE0_LOW) + 2 * s);
    localparam logic [CFG_IDX_W-1:0] HighIdx = CFG_IDX_W'(int'(CFG_RANGE0_LOW) + 2 * s + 1);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        range_low_r[s]  <= NEG_LIMIT;
        range_high_r[s] <= POS_LIMIT;
      end else if (cfg_we) begin
        if (cfg_index == LowIdx) begin
          range_low_r[s] <= cfg_wdata;
        end
        if (cfg_index == HighIdx) begin
          range_high_r[s] <= cfg_wdata;
        end
      end
    end
  end

  dirv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  dirv_range #(
    .RANGE_SLOTS (RANGE_SLOTS)
  ) u_range (
    .clk         (clk),
    .rst_n       (rst_n),
    .fin_valid   (fin_valid),
    .fin_ready   (fin_ready),
    .fin         (fin),
    .range_count (range_count_r),
    .range_low   (range_low_r),
    .range_high  (range_high_r),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .valid_res   (valid_res),
    .int_value   (int_value),
    .status      (status)
  );

  assign out_tdata = {4'b0, status, int_value, valid_res};

  // Terminator taken means a parsed result is staged on the next edge
  a_term_stages: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> fin_valid)
    else $error("terminator request did not stage a result");

  // Failed parses carry a zero value
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == ST_EMPTY || status == ST_BADCHAR || status == ST_TOOLARGE)
    |-> int_value == '0)
    else $error("nonzero value on failed parse");

  // valid flag agrees with the status code
  a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (valid_res == (status == ST_ACCEPTED)))
    else $error("valid_res disagrees with status");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

>>> src/dirv_parser.sv
// Character accumulator: sign, digits, exact overflow test, end-of-value result.
`timescale 1ns / 1ps

module dirv_parser
  import dirv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_last,
  output logic              fin_valid,
  input  logic              fin_ready,
  output dirv_fin_t         fin
);

  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic               at_start_r, at_start_nxt;
  logic               digit_seen_r, digit_seen_nxt;
  err_t               err_r, err_nxt;
  logic               fin_valid_r, fin_valid_nxt;
  dirv_fin_t          fin_r, fin_nxt;

  logic               accept;
  logic               is_digit;
  logic               is_sign;
  logic [VALUE_W+3:0] prod;
  logic               too_big;

  assign in_ready  = !fin_valid_r || fin_ready;
  assign accept    = in_valid && in_ready;
  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

  assign is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign is_sign  = (in_char == CH_PLUS) || (in_char == CH_MINUS);
  // mag*10 + digit, four spare bits expose any carry out of 64 bits
  assign prod = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1)
              + (VALUE_W+4)'(in_char[3:0]);
  assign too_big = neg_r ? (mag_r[VALUE_W-1] && (|mag_r[VALUE_W-2:0]))
                         : mag_r[VALUE_W-1];

  always_comb begin
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    at_start_nxt   = at_start_r;
    digit_seen_nxt = digit_seen_r;
    err_nxt        = err_r;
    fin_valid_nxt  = fin_valid_r && !fin_ready;
    fin_nxt        = fin_r;
    if (accept && in_last) begin
      fin_valid_nxt = 1'b1;
      fin_nxt.value = '0;
      case (err_r)
        ERR_BADCHAR:  fin_nxt.status = ST_BADCHAR;
        ERR_TOOLARGE: fin_nxt.status = ST_TOOLARGE;
        default: begin
          if (!digit_seen_r) begin
            fin_nxt.status = ST_EMPTY;
          end else if (too_big) begin
            fin_nxt.status = ST_TOOLARGE;
          end else begin
            fin_nxt.status = ST_ACCEPTED;
            fin_nxt.value  = neg_r ? (VALUE_W'(0) - mag_r) : mag_r;
          end
        end
      endcase
      mag_nxt        = '0;
      neg_nxt        = 1'b0;
      at_start_nxt   = 1'b1;
      digit_seen_nxt = 1'b0;
      err_nxt        = ERR_NONE;
    end else if (accept) begin
      at_start_nxt = 1'b0;
      if (at_start_r && is_sign) begin
        neg_nxt = (in_char == CH_MINUS);
      end else begin
        digit_seen_nxt = 1'b1;
        if (err_r == ERR_NONE) begin
          if (!is_digit) begin
            err_nxt = ERR_BADCHAR;
          end else if (|prod[VALUE_W+3:VALUE_W]) begin
            err_nxt = ERR_TOOLARGE;
          end else begin
            mag_nxt = prod[VALUE_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r        <= '0;
      neg_r        <= 1'b0;
      at_start_r   <= 1'b1;
      digit_seen_r <= 1'b0;
      err_r        <= ERR_NONE;
      fin_valid_r  <= 1'b0;
    end else begin
      mag_r        <= mag_nxt;
      neg_r        <= neg_nxt;
      at_start_r   <= at_start_nxt;
      digit_seen_r <= digit_seen_nxt;
      err_r        <= err_nxt;
      fin_valid_r  <= fin_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

endmodule

>>> src/dirv_range.sv
// Range check of the parsed value and the result register.
`timescale 1ns / 1ps

module dirv_range
  import dirv_pkg::*;
#(
  parameter int RANGE_SLOTS = RANGE_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fin_valid,
  output logic                      fin_ready,
  input  dirv_fin_t                 fin,
  input  logic [COUNT_W-1:0]        range_count,
  input  logic signed [VALUE_W-1:0] range_low  [RANGE_SLOTS],
  input  logic signed [VALUE_W-1:0] range_high [RANGE_SLOTS],
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic                      valid_res,
  output logic [VALUE_W-1:0]        int_value,
  output status_t                   status
);

  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] value_r;
  status_t            status_r, status_nxt;
  logic               hit;
  logic               load;

  assign fin_ready = !out_valid_r || res_ready;
  assign load      = fin_valid && fin_ready;

  // Slots are compared side by side
  always_comb begin
    hit = (range_count == '0);
    for (int i = 0; i < RANGE_SLOTS; i++) begin
      if ((i < int'(range_count)) &&
          (range_low[i] <= $signed(fin.value)) &&
          ($signed(fin.value) <= range_high[i])) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    status_nxt = fin.status;
    if (fin.status == ST_ACCEPTED && !hit) begin
      status_nxt = ST_OUT_RANGE;
    end
    out_valid_nxt = load || (out_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r  <= fin.value;
      status_r <= status_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign valid_res = (status_r == ST_ACCEPTED);
  assign int_value = value_r;
  assign status    = status_r;

endmodule
